/* design/ackt_pkg.sv */
// Package: shared types, codes and constants for the cook-timer controller.
`default_nettype none

package ackt_pkg;

  // Item modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_ENTRY = 2'd1;
  localparam logic [1:0] MODE_ABORT = 2'd2;

  // Stage codes
  localparam logic [1:0] ST_WAIT  = 2'd0;
  localparam logic [1:0] ST_COOK  = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;
  localparam logic [1:0] ST_ABORT = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LAMP_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT_MM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_MIN_MM     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_MAX_MM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ABORT_HOLD_TICKS = 3'd4;
  localparam int unsigned CFG_DATA_W = 11;

  // Reset values of the configuration registers
  localparam logic [9:0]  LAMP_THRESHOLD_RST   = 10'd30;
  localparam logic [10:0] NEAR_LIMIT_RST       = 11'd200;
  localparam logic [10:0] VALID_MIN_RST        = 11'd20;
  localparam logic [10:0] VALID_MAX_RST        = 11'd2000;
  localparam logic [1:0]  ABORT_HOLD_RST       = 2'd2;

  // Distance scaling: mm = echo * 17 / 600
  localparam int unsigned DIST_W = 22;
  localparam logic [DIST_W-1:0] ECHO_SCALE = 22'd17;
  localparam logic [DIST_W-1:0] MM_SCALE   = 22'd600;

  // Power knob quantization
  localparam logic [3:0] POWER_MAX  = 4'd10;
  localparam logic [9:0] POWER_STEP = 10'd100;

  // Event flag bits
  localparam int unsigned EV_WARN   = 0;
  localparam int unsigned EV_LAMP   = 1;
  localparam int unsigned EV_POWER  = 2;
  localparam int unsigned EV_LATCH  = 3;
  localparam int unsigned EV_FINISH = 4;
  localparam int unsigned EV_ABORT  = 5;

  typedef struct packed {
    logic [3:0] power_level;
    logic       warning_on;
    logic       lamp_on;
    logic [5:0] events;
  } sensor_res_t;

  typedef struct packed {
    logic [1:0] stage;
    logic [3:0] time_tens;
    logic [3:0] time_ones;
    logic       motor_on;
    logic       buzzer_on;
    logic       door_latched;
    logic [5:0] events;
  } timer_res_t;

  // (sample + 100) / 100 clamped to 10: one plus the count of steps passed
  function automatic logic [3:0] power_quantize(input logic [9:0] sample);
    logic [3:0] lvl;
    lvl = 4'd1;
    for (int k = 1; k < int'(POWER_MAX); k++) begin
      if (sample >= 10'(k * int'(POWER_STEP))) begin
        lvl = 4'(k + 1);
      end
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

/* design/ackt_if.sv */
// Interfaces: input item channel and result channel.
`default_nettype none

interface ackt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [3:0] tens_digit;
  logic [3:0] ones_digit;
  logic [15:0] echo_cycles;
  logic [9:0] brightness_sample;
  logic [9:0] power_sample;

  modport source (output valid, mode, tens_digit, ones_digit, echo_cycles,
                  brightness_sample, power_sample, input ready);
  modport sink   (input valid, mode, tens_digit, ones_digit, echo_cycles,
                  brightness_sample, power_sample, output ready);
endinterface

interface ackt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] stage;
  logic [3:0] time_tens;
  logic [3:0] time_ones;
  logic [3:0] power_level;
  logic       warning_on;
  logic       lamp_on;
  logic       motor_on;
  logic       buzzer_on;
  logic       door_latched;
  logic [5:0] event_flags;

  modport source (output valid, stage, time_tens, time_ones, power_level, warning_on,
                  lamp_on, motor_on, buzzer_on, door_latched, event_flags, input ready);
  modport sink   (input valid, stage, time_tens, time_ones, power_level, warning_on,
                  lamp_on, motor_on, buzzer_on, door_latched, event_flags, output ready);
endinterface

`default_nettype wire

/* design/ackt_sensor.sv */
// Sensor unit: echo distance warning, lamp switch and power quantization.
`default_nettype none

module ackt_sensor (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire logic [15:0]         echo_cycles,
  input  wire logic [9:0]          brightness_sample,
  input  wire logic [9:0]          power_sample,
  input  wire logic [9:0]          lamp_threshold,
  input  wire logic [10:0]         near_limit_mm,
  input  wire logic [10:0]         valid_min_mm,
  input  wire logic [10:0]         valid_max_mm,
  output ackt_pkg::sensor_res_t    res
);
  import ackt_pkg::*;

  logic              warning;
  logic              lamp;
  logic              warning_next;
  logic              lamp_next;
  logic [DIST_W-1:0] echo_scaled;
  logic [DIST_W-1:0] lo_bound;
  logic [DIST_W-1:0] hi_bound;
  logic [DIST_W-1:0] near_bound;
  logic              in_range;
  logic              near;

  // Compare echo*17 against limit*600 instead of dividing.
  // mm > min  <=>  echo*17 >= (min+1)*600
  assign echo_scaled = DIST_W'(echo_cycles) * ECHO_SCALE;
  assign lo_bound    = (DIST_W'(valid_min_mm) + DIST_W'(1)) * MM_SCALE;
  assign hi_bound    = DIST_W'(valid_max_mm) * MM_SCALE;
  assign near_bound  = DIST_W'(near_limit_mm) * MM_SCALE;
  assign in_range    = (echo_scaled >= lo_bound) && (echo_scaled < hi_bound);
  assign near        = echo_scaled < near_bound;

  always_comb begin
    warning_next = in_range ? near : warning;
    lamp_next    = brightness_sample < lamp_threshold;
    res.power_level = power_quantize(power_sample);
    res.warning_on  = warning_next;
    res.lamp_on     = lamp_next;
    res.events      = '0;
    res.events[EV_WARN] = in_range && near && !warning;
    res.events[EV_LAMP] = lamp_next != lamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warning <= 1'b0;
      lamp    <= 1'b0;
    end else if (fire) begin
      warning <= warning_next;
      lamp    <= lamp_next;
    end
  end

endmodule

`default_nettype wire

/* design/ackt_timer.sv */
// Timer sequencer: stage state, countdown, alarm toggling and abort hold.
`default_nettype none

module ackt_timer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [1:0]        mode,
  input  wire logic [3:0]        tens_digit,
  input  wire logic [3:0]        ones_digit,
  input  wire logic [3:0]        power_level,
  input  wire logic [1:0]        abort_hold_ticks,
  output ackt_pkg::timer_res_t   res
);
  import ackt_pkg::*;

  logic [1:0] stage,       stage_next;
  logic [3:0] tens_count,  tens_count_next;
  logic [3:0] ones_count,  ones_count_next;
  logic [3:0] last_power,  last_power_next;
  logic       alarm_phase, alarm_phase_next;
  logic       finish_seen, finish_seen_next;
  logic [1:0] abort_ticks, abort_ticks_next;
  logic       motor,       motor_next;
  logic [1:0] hold;
  logic [1:0] ticks_inc;
  logic [5:0] events;

  assign hold      = (abort_hold_ticks == 2'd0) ? 2'd1 : abort_hold_ticks;
  assign ticks_inc = abort_ticks + 2'd1;

  always_comb begin
    stage_next       = stage;
    tens_count_next  = tens_count;
    ones_count_next  = ones_count;
    last_power_next  = last_power;
    alarm_phase_next = alarm_phase;
    finish_seen_next = finish_seen;
    abort_ticks_next = abort_ticks;
    motor_next       = motor;
    events           = '0;
    case (mode)
      MODE_ABORT: begin
        stage_next       = ST_ABORT;
        alarm_phase_next = 1'b0;
        motor_next       = 1'b0;
        finish_seen_next = 1'b0;
        events[EV_ABORT] = 1'b1;
      end
      MODE_ENTRY: begin
        if (stage == ST_WAIT) begin
          tens_count_next  = tens_digit;
          ones_count_next  = ones_digit;
          last_power_next  = power_level;
          stage_next       = ST_COOK;
          events[EV_LATCH] = 1'b1;
        end
      end
      MODE_TICK: begin
        case (stage)
          ST_COOK: begin
            motor_next       = 1'b1;
            events[EV_POWER] = power_level != last_power;
            last_power_next  = power_level;
            if (ones_count != 4'd0) begin
              ones_count_next = ones_count - 4'd1;
            end else if (tens_count != 4'd0) begin
              ones_count_next = 4'd9;
              tens_count_next = tens_count - 4'd1;
            end else begin
              stage_next = ST_DONE;
              motor_next = 1'b0;
            end
          end
          ST_DONE: begin
            // first done tick forces the motor off before the toggle
            if (!finish_seen) begin
              events[EV_FINISH] = 1'b1;
              finish_seen_next  = 1'b1;
              motor_next        = 1'b1;
            end else begin
              motor_next = ~motor;
            end
            alarm_phase_next = ~alarm_phase;
          end
          ST_ABORT: begin
            motor_next = 1'b0;
            if (ticks_inc >= hold) begin
              stage_next       = ST_WAIT;
              abort_ticks_next = 2'd0;
            end else begin
              abort_ticks_next = ticks_inc;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    res.stage        = stage_next;
    res.time_tens    = tens_count_next;
    res.time_ones    = ones_count_next;
    res.motor_on     = motor_next;
    res.buzzer_on    = alarm_phase_next;
    res.door_latched = (stage_next == ST_COOK) || ((stage_next == ST_DONE) && !finish_seen_next);
    res.events       = events;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage       <= ST_WAIT;
      tens_count  <= 4'd0;
      ones_count  <= 4'd0;
      last_power  <= 4'd0;
      alarm_phase <= 1'b0;
      finish_seen <= 1'b0;
      abort_ticks <= 2'd0;
      motor       <= 1'b0;
    end else if (fire) begin
      stage       <= stage_next;
      tens_count  <= tens_count_next;
      ones_count  <= ones_count_next;
      last_power  <= last_power_next;
      alarm_phase <= alarm_phase_next;
      finish_seen <= finish_seen_next;
      abort_ticks <= abort_ticks_next;
      motor       <= motor_next;
    end
  end

endmodule

`default_nettype wire

/* design/appliance_cook_timer_controller_unit.sv */
// Top level: cook-timer controller with input register, config and result register.
//
//   channel   dir  handshake      transaction
//   items     in   valid/ready    mode, digits, echo, brightness, power sample
//   results   out  valid/ready    stage, digits, power, lamp/warn/motor/buzzer, flags
//   wr_*      in   write enable   register index + data, no read-back
//
// Cycles: one item per clock sustained while results are taken; the result register
// loads when the input register hands its item on, so a result passes the input
// register, then the result register, before it can be taken.
// Reset: rst is synchronous; stage goes to waiting, counters and the result valid
// clear, config takes its reset values.
// Stalls: a held result stops the input register only when both are full; the
// input register frees as the result is taken, so items keep flowing.
`default_nettype none

module appliance_cook_timer_controller_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  ackt_in_if.sink                               items,
  ackt_out_if.source                            results,
  input  wire logic                             wr_en,
  input  wire logic [ackt_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [ackt_pkg::CFG_DATA_W-1:0]  wr_data
);
  import ackt_pkg::*;

  // Configuration registers
  logic [9:0]  lamp_threshold;
  logic [10:0] near_limit_mm;
  logic [10:0] valid_min_mm;
  logic [10:0] valid_max_mm;
  logic [1:0]  abort_hold_ticks;

  // Input register
  logic        item_valid;
  logic [1:0]  item_mode;
  logic [3:0]  item_tens;
  logic [3:0]  item_ones;
  logic [15:0] item_echo;
  logic [9:0]  item_bright;
  logic [9:0]  item_power;

  logic        out_valid;
  logic        out_free;
  logic        fire;

  sensor_res_t sensor_res;
  timer_res_t  timer_res;

  // The result register takes a new result when empty or being drained.
  assign out_free    = !out_valid || results.ready;
  assign fire        = item_valid && out_free;
  assign items.ready = !item_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_threshold   <= LAMP_THRESHOLD_RST;
      near_limit_mm    <= NEAR_LIMIT_RST;
      valid_min_mm     <= VALID_MIN_RST;
      valid_max_mm     <= VALID_MAX_RST;
      abort_hold_ticks <= ABORT_HOLD_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_LAMP_THRESHOLD:   lamp_threshold   <= wr_data[9:0];
        REG_NEAR_LIMIT_MM:    near_limit_mm    <= wr_data[10:0];
        REG_VALID_MIN_MM:     valid_min_mm     <= wr_data[10:0];
        REG_VALID_MAX_MM:     valid_max_mm     <= wr_data[10:0];
        REG_ABORT_HOLD_TICKS: abort_hold_ticks <= wr_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: captures a transaction whenever it is free or moving on.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (items.ready) begin
      item_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      item_mode   <= items.mode;
      item_tens   <= items.tens_digit;
      item_ones   <= items.ones_digit;
      item_echo   <= items.echo_cycles;
      item_bright <= items.brightness_sample;
      item_power  <= items.power_sample;
    end
  end

  ackt_sensor u_sensor (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .echo_cycles       (item_echo),
    .brightness_sample (item_bright),
    .power_sample      (item_power),
    .lamp_threshold    (lamp_threshold),
    .near_limit_mm     (near_limit_mm),
    .valid_min_mm      (valid_min_mm),
    .valid_max_mm      (valid_max_mm),
    .res               (sensor_res)
  );

  ackt_timer u_timer (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .mode             (item_mode),
    .tens_digit       (item_tens),
    .ones_digit       (item_ones),
    .power_level      (sensor_res.power_level),
    .abort_hold_ticks (abort_hold_ticks),
    .res              (timer_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      results.stage        <= timer_res.stage;
      results.time_tens    <= timer_res.time_tens;
      results.time_ones    <= timer_res.time_ones;
      results.power_level  <= sensor_res.power_level;
      results.warning_on   <= sensor_res.warning_on;
      results.lamp_on      <= sensor_res.lamp_on;
      results.motor_on     <= timer_res.motor_on;
      results.buzzer_on    <= timer_res.buzzer_on;
      results.door_latched <= timer_res.door_latched;
      results.event_flags  <= timer_res.events | sensor_res.events;
    end
  end

  assign results.valid = out_valid;

  // An item in the input register waits there until it is processed.
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !fire |=> item_valid)
    else $error("input register dropped an unprocessed item");

  // Every processed item shows up as a result on the next cycle.
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed item produced no result");

  // The door is latched only while cooking or in the done stage.
  a_latch_stage: assert property (@(posedge clk) disable iff (rst)
    out_valid && results.door_latched |-> (results.stage == ST_COOK) ||
                                          (results.stage == ST_DONE))
    else $error("door latched outside cooking or done");

  // An abort flag always comes with the aborted stage.
  a_abort_stage: assert property (@(posedge clk) disable iff (rst)
    out_valid && results.event_flags[EV_ABORT] |-> results.stage == ST_ABORT)
    else $error("abort flag without aborted stage");

endmodule

`default_nettype wire

/* bench/appliance_cook_timer_controller_unit_tb.sv */
// Testbench for the cook-timer controller: directed table, then constrained-by-hand random phases.
`timescale 1ns / 1ps

module appliance_cook_timer_controller_unit_tb;
  import ackt_pkg::*;

  // Mode 3 has no meaning; the block must leave stage state alone on it.
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam int unsigned DIST_NUM = 17;   // mm = echo * 17 / 600
  localparam int unsigned DIST_DEN = 600;
  localparam int unsigned POWER_DIV = 100;
  localparam int unsigned POWER_TOP = 10;

  localparam int NUM_PHASES = 7;
  localparam int PHASE_ITEMS = 240;
  localparam int SETTLE_CYCLES = 6;        // idle clocks after the last owed status has arrived
  localparam int WATCHDOG_LIMIT = 4000;    // idle cycles before the bench declares a hang
  localparam int DIRECTED_N = 24;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  tens_digit;
    logic [3:0]  ones_digit;
    logic [15:0] echo_cycles;
    logic [9:0]  brightness_sample;
    logic [9:0]  power_sample;
  } item_t;

  typedef struct packed {
    logic [1:0] stage;
    logic [3:0] time_tens;
    logic [3:0] time_ones;
    logic [3:0] power_level;
    logic       warning_on;
    logic       lamp_on;
    logic       motor_on;
    logic       buzzer_on;
    logic       door_latched;
    logic [5:0] event_flags;
  } status_t;

  // typed = 1: the expected status is the one in the row, not the predictor's
  typedef struct packed {
    item_t   it;
    logic    typed;
    status_t exp;
  } dir_row_t;

  typedef struct {
    logic [9:0]  lamp;
    logic [10:0] near;
    logic [10:0] vmin;
    logic [10:0] vmax;
    logic [1:0]  hold;
  } settings_t;

  // Directed table. Defaults in force: lamp 30, near 200, min 20, max 2000, hold 2.
  // Echo 706 -> 20 mm (at min, ignored); 742 -> 21 mm; 7058 -> 199 mm; 7059 -> 200 mm.
  localparam dir_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    // right after reset: tick in waiting does nothing, power 0 -> level 1
    '{'{MODE_TICK, 4'd0, 4'd0, 16'd0, 10'd1023, 10'd0}, 1'b1,
      '{ST_WAIT, 4'd0, 4'd0, 4'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'b000000}},
    // undefined mode, max echo (far), dark -> lamp on, max power clamps to 10
    '{'{MODE_NONE, 4'd0, 4'd0, 16'd65535, 10'd0, 10'd1023}, 1'b1,
      '{ST_WAIT, 4'd0, 4'd0, 4'd10, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 6'b000010}},
    // entry with max digits, close echo -> warning rose + latched
    '{'{MODE_ENTRY, 4'd15, 4'd15, 16'd3000, 10'd29, 10'd999}, 1'b1,
      '{ST_COOK, 4'd15, 4'd15, 4'd10, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 6'b001001}},
    // abort while cooking, lamp threshold exactly -> lamp off
    '{'{MODE_ABORT, 4'd0, 4'd0, 16'd0, 10'd30, 10'd0}, 1'b1,
      '{ST_ABORT, 4'd15, 4'd15, 4'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 6'b100010}},
    '{'{MODE_TICK, 4'd0, 4'd0, 16'd706, 10'd30, 10'd0}, 1'b0, '0},
    '{'{MODE_TICK, 4'd0, 4'd0, 16'd7059, 10'd30, 10'd99}, 1'b0, '0},
    '{'{MODE_ENTRY, 4'd0, 4'd1, 16'd742, 10'd31, 10'd500}, 1'b0, '0},
    '{'{MODE_TICK, 4'd15, 4'd15, 16'd7058, 10'd1023, 10'd500}, 1'b0, '0},
    '{'{MODE_TICK, 4'd0, 4'd0, 16'd30000, 10'd0, 10'd100}, 1'b0, '0},
    '{'{MODE_TICK, 4'd0, 4'd0, 16'd1000, 10'd0, 10'd100}, 1'b0, '0},
    '{'{MODE_TICK, 4'd0, 4'd0, 16'd65535, 10'd512, 10'd0}, 1'b0, '0},
    '{'{MODE_TICK, 4'd0, 4'd0, 16'd5000, 10'd5, 10'd1023}, 1'b0, '0},
    '{'{MODE_ENTRY, 4'd9, 4'd9, 16'd0, 10'd5, 10'd250}, 1'b0, '0},
    '{'{MODE_NONE, 4'd15, 4'd15, 16'd0, 10'd1023, 10'd250}, 1'b0, '0},
    '{'{MODE_ABORT, 4'd0, 4'd0, 16'd2000, 10'd0, 10'd0}, 1'b0, '0},
    '{'{MODE_TICK, 4'd0, 4'd0, 16'd20000, 10'd0, 10'd0}, 1'b0, '0},
    '{'{MODE_TICK, 4'd0, 4'd0, 16'd4000, 10'd1023, 10'd0}, 1'b0, '0},
    '{'{MODE_TICK, 4'd0, 4'd0, 16'd4000, 10'd1023, 10'd0}, 1'b0, '0},
    '{'{MODE_ENTRY, 4'd1, 4'd0, 16'd0, 10'd0, 10'd1000}, 1'b0, '0},
    '{'{MODE_TICK, 4'd0, 4'd0, 16'd0, 10'd0, 10'd1000}, 1'b0, '0},
    '{'{MODE_ENTRY, 4'd5, 4'd5, 16'd0, 10'd0, 10'd1000}, 1'b0, '0},
    '{'{MODE_ABORT, 4'd0, 4'd0, 16'd0, 10'd0, 10'd1000}, 1'b0, '0},
    '{'{MODE_TICK, 4'd0, 4'd0, 16'd0, 10'd0, 10'd1000}, 1'b0, '0},
    '{'{MODE_TICK, 4'd0, 4'd0, 16'd0, 10'd0, 10'd1000}, 1'b0, '0}
  };

  logic clk;
  logic rst;
  logic wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  ackt_in_if  items_if ();
  ackt_out_if results_if ();

  appliance_cook_timer_controller_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .items    (items_if),
    .results  (results_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Mirror of the controller: configuration and state.
  logic [9:0]  lamp_cfg;
  logic [10:0] near_cfg;
  logic [10:0] vmin_cfg;
  logic [10:0] vmax_cfg;
  logic [1:0]  hold_cfg;

  logic [1:0] stage_q;
  logic [3:0] tens_q;
  logic [3:0] ones_q;
  logic [3:0] last_power_q;
  logic       warn_q;
  logic       lamp_q;
  logic       alarm_q;
  logic       finished_q;
  logic [1:0] abort_cnt_q;
  logic       motor_q;

  status_t pending_status_q [$];   // statuses owed by the block, oldest first
  int      fail_count;
  int      phase_items;
  int      burst_left;
  int      idle_cycles;
  logic [9:0] prev_power;
  logic [8:0] rx_cycle;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_mirror();
    lamp_cfg = LAMP_THRESHOLD_RST;
    near_cfg = NEAR_LIMIT_RST;
    vmin_cfg = VALID_MIN_RST;
    vmax_cfg = VALID_MAX_RST;
    hold_cfg = ABORT_HOLD_RST;
    stage_q = ST_WAIT;
    tens_q = '0;
    ones_q = '0;
    last_power_q = '0;
    warn_q = 1'b0;
    lamp_q = 1'b0;
    alarm_q = 1'b0;
    finished_q = 1'b0;
    abort_cnt_q = '0;
    motor_q = 1'b0;
  endfunction

  // Advance the mirror by one item and return the status the block should report.
  function automatic status_t cook_timer_next(input item_t it);
    int unsigned dist_mm;
    int unsigned lvl;
    logic        warn_new;
    logic        lamp_new;
    logic [1:0]  hold;
    logic [5:0]  ev;
    status_t     s;
    ev = '0;

    // Echo range: only a plausible distance moves the warning light.
    dist_mm = (32'(it.echo_cycles) * DIST_NUM) / DIST_DEN;
    if (dist_mm > vmin_cfg && dist_mm < vmax_cfg) begin
      warn_new = (dist_mm < near_cfg);
      if (warn_new && !warn_q) ev[EV_WARN] = 1'b1;
      warn_q = warn_new;
    end

    lamp_new = (it.brightness_sample < lamp_cfg);
    if (lamp_new != lamp_q) ev[EV_LAMP] = 1'b1;
    lamp_q = lamp_new;

    lvl = (32'(it.power_sample) + POWER_DIV) / POWER_DIV;
    if (lvl > POWER_TOP) lvl = POWER_TOP;

    case (it.mode)
      MODE_ABORT: begin
        // abort count is deliberately not restarted here
        stage_q = ST_ABORT;
        alarm_q = 1'b0;
        motor_q = 1'b0;
        finished_q = 1'b0;
        ev[EV_ABORT] = 1'b1;
      end
      MODE_ENTRY: begin
        if (stage_q == ST_WAIT) begin
          tens_q = it.tens_digit;
          ones_q = it.ones_digit;
          last_power_q = 4'(lvl);
          stage_q = ST_COOK;
          ev[EV_LATCH] = 1'b1;
        end
      end
      MODE_TICK: begin
        case (stage_q)
          ST_COOK: begin
            motor_q = 1'b1;
            if (4'(lvl) != last_power_q) ev[EV_POWER] = 1'b1;
            last_power_q = 4'(lvl);
            if (ones_q != 0) begin
              ones_q = ones_q - 4'd1;
            end else if (tens_q != 0) begin
              ones_q = 4'd9;
              tens_q = tens_q - 4'd1;
            end else begin
              stage_q = ST_DONE;
              motor_q = 1'b0;
            end
          end
          ST_DONE: begin
            // first done tick: finished event, motor restarts its blink from off
            if (!finished_q) begin
              motor_q = 1'b0;
              ev[EV_FINISH] = 1'b1;
              finished_q = 1'b1;
            end
            motor_q = ~motor_q;
            alarm_q = ~alarm_q;
          end
          ST_ABORT: begin
            hold = (hold_cfg == 0) ? 2'd1 : hold_cfg;
            motor_q = 1'b0;
            abort_cnt_q = abort_cnt_q + 2'd1;
            if (abort_cnt_q >= hold) begin
              stage_q = ST_WAIT;
              abort_cnt_q = '0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    s.stage = stage_q;
    s.time_tens = tens_q;
    s.time_ones = ones_q;
    s.power_level = 4'(lvl);
    s.warning_on = warn_q;
    s.lamp_on = lamp_q;
    s.motor_on = motor_q;
    s.buzzer_on = alarm_q;
    s.door_latched = (stage_q == ST_COOK) || (stage_q == ST_DONE && !finished_q);
    s.event_flags = ev;
    return s;
  endfunction

  // Sensor fields, biased toward the configured boundaries.
  function automatic item_t make_item(input logic [1:0] mode, input logic [3:0] tens,
                                      input logic [3:0] ones);
    item_t it;
    int    target_mm;
    int    echo;
    int    bright;
    it.mode = mode;
    it.tens_digit = tens;
    it.ones_digit = ones;

    case ($urandom_range(0, 3))
      0: echo = $urandom_range(0, 65535);
      1: echo = $urandom_range(0, 8000);
      default: begin
        case ($urandom_range(0, 2))
          0: target_mm = near_cfg;
          1: target_mm = vmin_cfg;
          default: target_mm = vmax_cfg;
        endcase
        echo = (target_mm * int'(DIST_DEN)) / int'(DIST_NUM) + $urandom_range(0, 100) - 50;
      end
    endcase
    if (echo < 0) echo = 0;
    if (echo > 65535) echo = 65535;
    it.echo_cycles = 16'(echo);

    if ($urandom_range(0, 1) == 0) begin
      bright = $urandom_range(0, 1023);
    end else begin
      bright = int'(lamp_cfg) + $urandom_range(0, 6) - 3;
      if (bright < 0) bright = 0;
      if (bright > 1023) bright = 1023;
    end
    it.brightness_sample = 10'(bright);

    // hold the knob now and then so power-change events are not constant
    if ($urandom_range(0, 9) >= 3) prev_power = 10'($urandom_range(0, 1023));
    it.power_sample = prev_power;
    return it;
  endfunction

  // Sender pacing: bursts of random length, then a gap; now and then a long burst.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(0, 12);
    end
  endtask

  // One input transaction; the status it causes is queued on acceptance.
  task automatic push_item(input item_t it, input logic typed, input status_t exp);
    status_t s;
    items_if.valid <= 1'b1;
    items_if.mode <= it.mode;
    items_if.tens_digit <= it.tens_digit;
    items_if.ones_digit <= it.ones_digit;
    items_if.echo_cycles <= it.echo_cycles;
    items_if.brightness_sample <= it.brightness_sample;
    items_if.power_sample <= it.power_sample;
    do @(posedge clk); while (!items_if.ready);
    s = cook_timer_next(it);
    pending_status_q.push_back(typed ? exp : s);
    if (it.mode != MODE_NONE) phase_items++;
    pace_sender();
  endtask

  task automatic push_random(input logic [1:0] mode, input logic [3:0] tens,
                             input logic [3:0] ones);
    push_item(make_item(mode, tens, ones), 1'b0, '0);
  endtask

  // A well-formed cook: back to waiting, entry, count down, a few done ticks,
  // sometimes cut short by an abort.
  task automatic run_cook_cycle();
    logic [3:0] tens;
    logic [3:0] ones;
    int         pick;
    int         n_ticks;
    int         abort_at;
    if (stage_q != ST_WAIT) begin
      if (stage_q != ST_ABORT) push_random(MODE_ABORT, 4'($urandom), 4'($urandom));
      while (stage_q != ST_WAIT) push_random(MODE_TICK, 4'($urandom), 4'($urandom));
    end

    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      tens = 4'($urandom_range(0, 15));
      ones = 4'($urandom_range(0, 15));
    end else if (pick < 4) begin
      tens = 4'($urandom_range(0, 9));
      ones = 4'($urandom_range(0, 9));
    end else begin
      tens = 4'($urandom_range(0, 1));
      ones = 4'($urandom_range(0, 9));
    end
    push_random(MODE_ENTRY, tens, ones);

    n_ticks = int'(tens) * 10 + int'(ones) + 1 + $urandom_range(0, 4);
    abort_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n_ticks - 1) : -1;
    for (int k = 0; k < n_ticks; k++) begin
      if (k == abort_at) begin
        push_random(MODE_ABORT, 4'($urandom), 4'($urandom));
        break;
      end
      push_random(MODE_TICK, 4'($urandom), 4'($urandom));
    end
  endtask

  // Noise: any mode in any stage, including the undefined one.
  task automatic run_noise();
    logic [1:0] mode;
    int         n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      mode = ($urandom_range(0, 15) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
      push_random(mode, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end
  endtask

  // Stop sending and let the block drain completely.
  task automatic settle();
    items_if.valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= CFG_DATA_W'(data);
    @(posedge clk);
  endtask

  task automatic write_settings(input settings_t c);
    write_reg(REG_LAMP_THRESHOLD, c.lamp);
    write_reg(REG_NEAR_LIMIT_MM, c.near);
    write_reg(REG_VALID_MIN_MM, c.vmin);
    write_reg(REG_VALID_MAX_MM, c.vmax);
    write_reg(REG_ABORT_HOLD_TICKS, c.hold);
    wr_en <= 1'b0;
    @(posedge clk);
    lamp_cfg = c.lamp;
    near_cfg = c.near;
    vmin_cfg = c.vmin;
    vmax_cfg = c.vmax;
    hold_cfg = c.hold;
  endtask

  // Phase 1 and 2 are the extremes, 3 a middle setting, the rest random.
  function automatic settings_t settings_for(input int phase);
    settings_t c;
    case (phase)
      1: c = '{lamp: 10'd1023, near: 11'd2047, vmin: 11'd0, vmax: 11'd2047, hold: 2'd3};
      2: c = '{lamp: 10'd0, near: 11'd0, vmin: 11'd2047, vmax: 11'd0, hold: 2'd1};
      3: c = '{lamp: 10'd512, near: 11'd1000, vmin: 11'd100, vmax: 11'd1500, hold: 2'd2};
      default: begin
        c.lamp = 10'($urandom_range(0, 1023));
        c.near = 11'($urandom_range(0, 2047));
        c.vmin = 11'($urandom_range(0, 300));
        c.vmax = 11'($urandom_range(1000, 2047));
        c.hold = 2'($urandom_range(1, 3));
      end
    endcase
    return c;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // Result side: each accepted status is checked against the oldest owed one.
  always @(posedge clk) begin : status_check
    status_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_status_q.size() == 0) begin
        $display("%0t: status transaction with nothing expected, actual stage %0d flags %b",
                 $time, results_if.stage, results_if.event_flags);
        fail_count++;
      end else begin
        want = pending_status_q.pop_front();
        check_field("stage", want.stage, results_if.stage);
        check_field("time_tens", want.time_tens, results_if.time_tens);
        check_field("time_ones", want.time_ones, results_if.time_ones);
        check_field("power_level", want.power_level, results_if.power_level);
        check_field("warning_on", want.warning_on, results_if.warning_on);
        check_field("lamp_on", want.lamp_on, results_if.lamp_on);
        check_field("motor_on", want.motor_on, results_if.motor_on);
        check_field("buzzer_on", want.buzzer_on, results_if.buzzer_on);
        check_field("door_latched", want.door_latched, results_if.door_latched);
        check_field("event_flags", want.event_flags, results_if.event_flags);
      end
    end
  end

  // Receiver stalls: the pattern steps with rx_cycle[8:7] -- always ready,
  // coin flip, ready when rx_cycle[1:0] is zero, and ready only when rx_cycle[4:0] >= 12.
  always @(posedge clk) begin
    if (rst) begin
      rx_cycle <= '0;
      results_if.ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 9'd1;
      case (rx_cycle[8:7])
        2'd0: results_if.ready <= 1'b1;
        2'd1: results_if.ready <= 1'($urandom_range(0, 1));
        2'd2: results_if.ready <= (rx_cycle[1:0] == 2'd0);
        default: results_if.ready <= (rx_cycle[4:0] >= 5'd12);
      endcase
    end
  end

  // Watchdog: too long with no transaction on either channel means a hang.
  always @(posedge clk) begin
    if (rst || (items_if.valid && items_if.ready) || (results_if.valid && results_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d statuses still owed",
               $time, idle_cycles, pending_status_q.size());
      $display("appliance_cook_timer_controller_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    items_if.valid = 1'b0;
    items_if.mode = MODE_TICK;
    items_if.tens_digit = '0;
    items_if.ones_digit = '0;
    items_if.echo_cycles = '0;
    items_if.brightness_sample = '0;
    items_if.power_sample = '0;
    fail_count = 0;
    burst_left = 0;
    prev_power = '0;
    clear_mirror();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      phase_items = 0;
      if (phase == 0) begin
        // directed table first, with reset settings still in force
        for (int r = 0; r < DIRECTED_N; r++) begin
          push_item(DIRECTED_ROWS[r].it, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].exp);
        end
      end else begin
        // registers only change with the block drained
        settle();
        write_settings(settings_for(phase));
      end
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) run_cook_cycle();
        else run_noise();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("appliance_cook_timer_controller_unit regression: pass");
    end else begin
      $display("appliance_cook_timer_controller_unit regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ackt_pkg.sv
design/ackt_if.sv
design/ackt_sensor.sv
design/ackt_timer.sv
design/appliance_cook_timer_controller_unit.sv
bench/appliance_cook_timer_controller_unit_tb.sv
